@@ rtl/bsaf_pkg.sv @@
// Shared types, constants and helper functions of the base-7 sequence filter.
// Depends on nothing; every other file of the block refers to it by scoped names.
`default_nettype none

package bsaf_pkg;

	// Field widths
	localparam int CODE_W  = 26;
	localparam int CNT_W   = 26;
	localparam int DIGITS  = 9;
	localparam int DIGIT_W = 3;

	// Stream widths: input tdata holds code, output tdata holds the result record
	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 112;

	// Configuration port
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 6;
	localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_SUM         = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_ORDER_MINUS_LAMBDA = 1'b1;
	localparam logic signed [5:0] TARGET_SUM_RST = 6'sd6;
	localparam logic [4:0]        OML_RST        = 5'd9;

	// Default depth of the queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// Saturation value of the counters
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// Reciprocal for division by 7 of a 26-bit value: (v * M) >> 29 is exact
	localparam logic [26:0] DIV7_MAGIC = 27'd76695845;
	localparam int          DIV7_SHIFT = 29;

	// Reciprocal for division by 6 of an 11-bit value: (u * M) >> 14 is exact
	localparam logic [11:0] DIV6_MAGIC = 12'd2731;
	localparam int          DIV6_SHIFT = 14;

	// Offset that makes the B numerator non-negative; a multiple of 6
	localparam logic signed [11:0] BNUM_OFFSET = 12'sd276;

	// Live configuration
	typedef struct packed {
		logic signed [5:0] target_sum;
		logic [4:0]        order_minus_lambda;
	} cfg_t;

	// Classified candidate travelling from front to back
	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic              last;
		logic              principal;
		logic              prefinal;
		logic              survivor;
	} item_t;

	function automatic logic [CODE_W-1:0] div7(input logic [CODE_W-1:0] v);
		logic [52:0] p;
		p = 53'(v) * 53'(DIV7_MAGIC);
		return CODE_W'(p >> DIV7_SHIFT);
	endfunction

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
		return (c == CNT_MAX) ? CNT_MAX : c + CNT_W'(1);
	endfunction

endpackage

`default_nettype wire

@@ rtl/bsaf_front.sv @@
// Front part: digit extraction pipeline and classification of each candidate.
// Depends on bsaf_pkg; feeds bsaf_queue.
`default_nettype none

module bsaf_front (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire bsaf_pkg::cfg_t                    cfg,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [bsaf_pkg::CODE_W-1:0]       in_code,
	input  wire logic                              in_last,
	output logic                                   out_valid,
	input  wire logic                              out_full,
	output bsaf_pkg::item_t                        out_item
);

	localparam int DIGITS = bsaf_pkg::DIGITS;
	localparam int CODE_W = bsaf_pkg::CODE_W;
	localparam int DW     = bsaf_pkg::DIGIT_W;

	// Whole pipeline moves together; it holds only when the tail cannot drain
	logic en;
	logic vld_s12;
	assign en        = !vld_s12 || !out_full;
	assign in_ready  = en;
	assign out_valid = vld_s12;

	// Digit stages: stage k divides by 7 and keeps digit k
	logic                          vld_dg_s  [DIGITS];
	logic [CODE_W-1:0]             quot_dg_s [DIGITS];
	logic [CODE_W-1:0]             code_dg_s [DIGITS];
	logic                          last_dg_s [DIGITS];
	logic [DIGITS-1:0][DW-1:0]     dig_dg_s  [DIGITS];

	for (genvar k = 0; k < DIGITS; k++) begin : g_dig
		logic                      vld_in;
		logic [CODE_W-1:0]         q_in;
		logic [CODE_W-1:0]         code_w;
		logic                      last_w;
		logic [DIGITS-1:0][DW-1:0] dig_in;
		logic [DIGITS-1:0][DW-1:0] dig_nx;
		logic [CODE_W-1:0]         quot;
		logic [CODE_W-1:0]         rem;

		if (k == 0) begin : g_head
			assign vld_in = in_valid;
			assign q_in   = in_code;
			assign code_w = in_code;
			assign last_w = in_last;
			assign dig_in = '0;
		end else begin : g_body
			assign vld_in = vld_dg_s[k-1];
			assign q_in   = quot_dg_s[k-1];
			assign code_w = code_dg_s[k-1];
			assign last_w = last_dg_s[k-1];
			assign dig_in = dig_dg_s[k-1];
		end

		// remainder = q - 7*quot
		assign quot = bsaf_pkg::div7(q_in);
		assign rem  = q_in - ((quot << 3) - quot);

		always_comb begin
			dig_nx    = dig_in;
			dig_nx[k] = rem[DW-1:0];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_dg_s[k] <= 1'b0;
			end else if (en) begin
				vld_dg_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				quot_dg_s[k] <= quot;
				code_dg_s[k] <= code_w;
				last_dg_s[k] <= last_w;
				dig_dg_s[k]  <= dig_nx;
			end
		end
	end

	// Stage 10: digit sum, sum of squares, cyclic correlations at shifts 1..4
	logic                     vld_s10;
	logic [CODE_W-1:0]        code_s10;
	logic                     last_s10;
	logic signed [6:0]        sum_s10;
	logic signed [7:0]        sq_s10;
	logic signed [7:0]        corr_s10 [4];

	logic signed [7:0]        sum_c;
	logic signed [7:0]        sq_c;
	logic signed [7:0]        corr_c [4];

	always_comb begin
		logic signed [7:0] sx [DIGITS];
		logic [DIGITS-1:0][DW-1:0] d;
		d     = dig_dg_s[DIGITS-1];
		sum_c = '0;
		sq_c  = '0;
		for (int j = 0; j < DIGITS; j++) begin
			sx[j] = 8'($signed({1'b0, d[j]}) - 4'sd3);
			sum_c = sum_c + sx[j];
			sq_c  = sq_c + sx[j] * sx[j];
		end
		for (int t = 0; t < 4; t++) begin
			corr_c[t] = '0;
			for (int j = 0; j < DIGITS; j++) begin
				corr_c[t] = corr_c[t] + sx[j] * sx[(j - (t + 1) + DIGITS) % DIGITS];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s10 <= 1'b0;
		end else if (en) begin
			vld_s10 <= vld_dg_s[DIGITS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			code_s10 <= code_dg_s[DIGITS-1];
			last_s10 <= last_dg_s[DIGITS-1];
			sum_s10  <= 7'(sum_c);
			sq_s10   <= sq_c;
			for (int t = 0; t < 4; t++) begin
				corr_s10[t] <= corr_c[t];
			end
		end
	end

	// Stage 11: A, B numerator, reciprocal multiply for the divisibility test, compares
	logic              vld_s11;
	logic [CODE_W-1:0] code_s11;
	logic              last_s11;
	logic              principal_s11;
	logic              c3_ok_s11;
	logic              b_ok_s11;
	logic [10:0]       u_s11;
	logic [7:0]        q6_s11;

	logic signed [11:0] n12;
	logic signed [11:0] sum12;
	logic signed [11:0] sq12;
	logic signed [11:0] a12;
	logic signed [11:0] bnum12;
	logic signed [11:0] tgt12;
	logic signed [11:0] c12 [4];
	logic [10:0]        u_c;
	logic [24:0]        prod6;
	logic               b_ok_c;

	always_comb begin
		n12    = $signed(12'(cfg.order_minus_lambda));
		sum12  = 12'(sum_s10);
		sq12   = 12'(sq_s10);
		tgt12  = 12'(cfg.target_sum);
		a12    = sq12 - n12;
		bnum12 = sum12 * sum12 - n12 - (a12 + (a12 <<< 1));
		u_c    = 11'(bnum12 + bsaf_pkg::BNUM_OFFSET);
		prod6  = 25'(u_c) * 25'(bsaf_pkg::DIV6_MAGIC);
		for (int t = 0; t < 4; t++) begin
			c12[t] = 12'(corr_s10[t]);
		end
		// shifts 1, 2 and 4 must match B, tested as 6*corr == numerator
		b_ok_c = ((c12[0] <<< 2) + (c12[0] <<< 1) == bnum12) &&
		         ((c12[1] <<< 2) + (c12[1] <<< 1) == bnum12) &&
		         ((c12[3] <<< 2) + (c12[3] <<< 1) == bnum12);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s11 <= 1'b0;
		end else if (en) begin
			vld_s11 <= vld_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			code_s11      <= code_s10;
			last_s11      <= last_s10;
			principal_s11 <= (sum12 == tgt12);
			c3_ok_s11     <= (c12[2] == a12);
			b_ok_s11      <= b_ok_c;
			u_s11         <= u_c;
			q6_s11        <= 8'(prod6 >> bsaf_pkg::DIV6_SHIFT);
		end
	end

	// Stage 12: remainder check and final class flags
	logic [10:0] six_q;
	logic        div_ok;
	logic        prefinal_c;

	assign six_q      = (11'(q6_s11) << 2) + (11'(q6_s11) << 1);
	assign div_ok     = (u_s11 == six_q);
	assign prefinal_c = principal_s11 && div_ok && c3_ok_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s12 <= 1'b0;
		end else if (en) begin
			vld_s12 <= vld_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_item.code      <= code_s11;
			out_item.last      <= last_s11;
			out_item.principal <= principal_s11;
			out_item.prefinal  <= prefinal_c;
			out_item.survivor  <= prefinal_c && b_ok_s11;
		end
	end

endmodule

`default_nettype wire

@@ rtl/bsaf_queue.sv @@
// Short queue of classified candidates between front and back.
// Depends on bsaf_pkg for the entry type.
`default_nettype none

module bsaf_queue #(
	parameter int DEPTH = bsaf_pkg::QUEUE_DEPTH
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire bsaf_pkg::item_t push_item,
	output logic                 full,
	input  wire logic            pop,
	output bsaf_pkg::item_t      pop_item,
	output logic                 empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	bsaf_pkg::item_t   mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_item = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/bsaf_back.sv @@
// Back part: class counters, first survivor, and the result register.
// Depends on bsaf_pkg; drains bsaf_queue.
`default_nettype none

module bsaf_back (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              q_empty,
	input  wire bsaf_pkg::item_t                   q_item,
	output logic                                   q_pop,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [bsaf_pkg::M_TDATA_W-1:0]         m_tdata
);

	localparam int CNT_W  = bsaf_pkg::CNT_W;
	localparam int CODE_W = bsaf_pkg::CODE_W;
	localparam int PAD_W  = bsaf_pkg::M_TDATA_W - 4 * CNT_W - 1;

	logic [CNT_W-1:0]  principal_q;
	logic [CNT_W-1:0]  prefinal_q;
	logic [CNT_W-1:0]  survivor_q;
	logic [CODE_W-1:0] first_q;

	logic [CNT_W-1:0]  principal_nx;
	logic [CNT_W-1:0]  prefinal_nx;
	logic [CNT_W-1:0]  survivor_nx;
	logic [CODE_W-1:0] first_nx;

	logic [CNT_W-1:0]  out_principal_q;
	logic [CNT_W-1:0]  out_prefinal_q;
	logic [CNT_W-1:0]  out_survivor_q;
	logic [CODE_W-1:0] out_first_q;
	logic              out_any_q;
	logic              out_vld_q;

	// Only a closing transaction needs the result register free or draining
	assign q_pop = !q_empty && (!q_item.last || !out_vld_q || m_tready);

	// Counter updates for the popped candidate
	always_comb begin
		principal_nx = q_item.principal ? bsaf_pkg::sat_inc(principal_q) : principal_q;
		prefinal_nx  = q_item.prefinal  ? bsaf_pkg::sat_inc(prefinal_q)  : prefinal_q;
		survivor_nx  = q_item.survivor  ? bsaf_pkg::sat_inc(survivor_q)  : survivor_q;
		first_nx     = (q_item.survivor && survivor_q == '0) ? q_item.code : first_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			principal_q <= '0;
			prefinal_q  <= '0;
			survivor_q  <= '0;
			first_q     <= '0;
			out_vld_q   <= 1'b0;
		end else begin
			if (q_pop) begin
				if (q_item.last) begin
					principal_q <= '0;
					prefinal_q  <= '0;
					survivor_q  <= '0;
					first_q     <= '0;
				end else begin
					principal_q <= principal_nx;
					prefinal_q  <= prefinal_nx;
					survivor_q  <= survivor_nx;
					first_q     <= first_nx;
				end
			end
			priority if (q_pop && q_item.last) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end else begin
				out_vld_q <= out_vld_q;
			end
		end
	end

	// Result record for the end of a scan
	always_ff @(posedge clk) begin
		if (q_pop && q_item.last) begin
			out_principal_q <= principal_nx;
			out_prefinal_q  <= prefinal_nx;
			out_survivor_q  <= survivor_nx;
			out_first_q     <= first_nx;
			out_any_q       <= (survivor_nx != '0);
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {PAD_W'(0), out_any_q, out_first_q, out_survivor_q,
	                   out_prefinal_q, out_principal_q};

endmodule

`default_nettype wire

@@ rtl/base7_sequence_autocorrelation_filter_core.sv @@
// Top level of the base-7 sequence filter: configuration registers and the
// front, queue and back parts. Depends on bsaf_pkg, bsaf_front, bsaf_queue, bsaf_back.
//
// One candidate code is accepted per clock cycle unless the full queue stalls the
// twelve-stage front pipeline (nine divide-by-7 stages, one correlation stage and
// two compare stages) moving one stage per cycle. A result record for the code
// marked tlast leaves through these stages and the result register, after any wait
// in the queue; codes without tlast give no output. The queue of QUEUE_DEPTH
// entries absorbs output back-pressure: a result waiting at the output holds back
// only the next code marked tlast, and the front stops only once the queue behind
// it is full. There is no clearing pass after reset.
// Configuration writes are always taken and should only be made while idle.
`default_nettype none

module base7_sequence_autocorrelation_filter_core #(
	parameter int QUEUE_DEPTH = bsaf_pkg::QUEUE_DEPTH
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// input tdata: [25:0] code, rest zero
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [bsaf_pkg::S_TDATA_W-1:0]      s_tdata,
	input  wire logic                                s_tlast,
	// output tdata: [25:0] principal_count, [51:26] prefinal_count,
	// [77:52] survivor_count, [103:78] first_survivor_code, [104] any_survivor
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic [bsaf_pkg::M_TDATA_W-1:0]           m_tdata,
	// configuration write channel
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [bsaf_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [bsaf_pkg::CFG_DATA_W-1:0]     cfg_data
);

	bsaf_pkg::cfg_t  cfg_q;
	bsaf_pkg::item_t fr_item;
	bsaf_pkg::item_t bk_item;
	logic            fr_valid;
	logic            q_full;
	logic            q_empty;
	logic            q_pop;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_sum         <= bsaf_pkg::TARGET_SUM_RST;
			cfg_q.order_minus_lambda <= bsaf_pkg::OML_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				bsaf_pkg::CFG_TARGET_SUM:
					cfg_q.target_sum <= $signed(cfg_data[5:0]);
				bsaf_pkg::CFG_ORDER_MINUS_LAMBDA:
					cfg_q.order_minus_lambda <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	bsaf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_code   (s_tdata[bsaf_pkg::CODE_W-1:0]),
		.in_last   (s_tlast),
		.out_valid (fr_valid),
		.out_full  (q_full),
		.out_item  (fr_item)
	);

	bsaf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fr_valid && !q_full),
		.push_item (fr_item),
		.full      (q_full),
		.pop       (q_pop),
		.pop_item  (bk_item),
		.empty     (q_empty)
	);

	bsaf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_item   (bk_item),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

`default_nettype wire

@@ rtl/bsaf_checker.sv @@
// Port-level checks on the result stream of the base-7 sequence filter.
// Depends on bsaf_pkg; bound to base7_sequence_autocorrelation_filter_core.
`default_nettype none

module bsaf_checker (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                m_tvalid,
	input  wire logic                                m_tready,
	input  wire logic [bsaf_pkg::M_TDATA_W-1:0]      m_tdata
);

	logic [25:0] principal;
	logic [25:0] prefinal;
	logic [25:0] survivor;
	logic [25:0] first;
	logic        any;

	assign principal = m_tdata[25:0];
	assign prefinal  = m_tdata[51:26];
	assign survivor  = m_tdata[77:52];
	assign first     = m_tdata[103:78];
	assign any       = m_tdata[104];

	// A stalled result transaction holds its record
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// The survivor flag follows the survivor count
	a_any: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (any == (survivor != '0)))
		else $error("any_survivor disagrees with survivor_count");

	// Each class is a subset of the one before it
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (survivor <= prefinal) && (prefinal <= principal))
		else $error("class counts out of order");

	// Without a survivor the kept code is zero
	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !any |-> (first == '0))
		else $error("first survivor code set without a survivor");

endmodule

bind base7_sequence_autocorrelation_filter_core bsaf_checker u_bsaf_checker (.*);

`default_nettype wire

@@ tb/base7_sequence_autocorrelation_filter_core_tb.sv @@
// Self-checking testbench for the base-7 sequence autocorrelation filter core.
// Predicts the scan reports from its own model of the digit filter and counters.
// Depends on bsaf_pkg and base7_sequence_autocorrelation_filter_core.
`timescale 1ns / 100ps

module base7_sequence_autocorrelation_filter_core_tb;

	localparam int RAND_PHASES  = 10;
	localparam int PHASE_ITEMS  = 125;
	localparam int DIR_ROWS     = 24;
	localparam int TOTAL_ITEMS  = RAND_PHASES * PHASE_ITEMS + DIR_ROWS;
	localparam int SETTLE_TICKS = 40;
	localparam int POOL_MAX     = 12;

	// Codes with a simple digit pattern
	localparam logic [25:0] CODE_ALL_MIN  = 26'd0;         // every entry -3
	localparam logic [25:0] CODE_ALL_MAX  = 26'd40353606;  // every entry +3
	localparam logic [25:0] CODE_WRAP     = 26'd40353607;  // 7^9, digits as code 0
	localparam logic [25:0] CODE_TOP      = 26'h3FFFFFF;
	localparam logic [25:0] CODE_ZEROES   = 26'd20176803;  // every entry 0
	localparam logic [25:0] CODE_SUM6     = 26'd20176827;  // entries 3,3,0,...
	localparam logic [25:0] CODE_ALL_TWO  = 26'd33628005;  // every entry +2

	typedef enum logic [1:0] {GR_NONE, GR_PRINCIPAL, GR_PREFINAL, GR_SURVIVOR} grade_e;
	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;
	typedef enum logic [2:0] {K_BALANCED, K_PERIODIC, K_NUDGED, K_POOL, K_NOISE} code_kind_e;

	// Result record, lowest field in the lowest bits
	typedef struct packed {
		logic        any_survivor;
		logic [25:0] first_code;
		logic [25:0] survivor_count;
		logic [25:0] prefinal_count;
		logic [25:0] principal_count;
	} report_t;

	typedef struct {
		row_kind_e   kind;
		logic [0:0]  idx;
		logic [5:0]  data;
		logic [25:0] code;
		logic        last;
		logic        typed;
		report_t     rep;
	} row_t;

	logic                                 clk = 1'b0;
	logic                                 arst_n = 1'b0;
	logic                                 s_tvalid = 1'b0;
	logic                                 s_tready;
	logic [bsaf_pkg::S_TDATA_W-1:0]       s_tdata = '0;
	logic                                 s_tlast = 1'b0;
	logic                                 m_tvalid;
	logic                                 m_tready = 1'b0;
	logic [bsaf_pkg::M_TDATA_W-1:0]       m_tdata;
	logic                                 cfg_valid = 1'b0;
	logic                                 cfg_ready;
	logic [bsaf_pkg::CFG_INDEX_W-1:0]     cfg_index = '0;
	logic [bsaf_pkg::CFG_DATA_W-1:0]      cfg_data = '0;

	// Predictor state and live configuration
	int          want_target = 6;
	int          want_oml = 9;
	logic [25:0] prin_tally = '0;
	logic [25:0] pref_tally = '0;
	logic [25:0] surv_tally = '0;
	logic [25:0] first_code = '0;
	report_t     scan_reports_q [$];
	logic [25:0] survivor_pool [$];

	int errors = 0;
	int items_sent = 0;
	int send_idle_pct = 23;
	int recv_idle_pct = 76;

	base7_sequence_autocorrelation_filter_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),   // [25:0] code, rest zero
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),   // principal, prefinal, survivor, first code, any
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 50 MHz clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Cyclic autocorrelation of the nine entries at shift t
	function automatic int corr(input int s [9], input int t);
		int acc;
		acc = 0;
		for (int j = 0; j < 9; j++)
			acc += s[j] * s[(j - t + 9) % 9];
		return acc;
	endfunction

	// How far a code gets through the filter under the live configuration
	function automatic grade_e grade_code(input logic [25:0] code);
		int s [9];
		int q, sum, sq, a, bnum, b;
		q = int'(code);
		sum = 0;
		sq = 0;
		for (int j = 0; j < 9; j++) begin
			s[j] = q % 7 - 3;
			q = q / 7;
			sum += s[j];
			sq += s[j] * s[j];
		end
		if (sum != want_target)
			return GR_NONE;
		a = sq - want_oml;
		bnum = sum * sum - want_oml - 3 * a;
		if (bnum % 6 != 0 || corr(s, 3) != a)
			return GR_PRINCIPAL;
		b = bnum / 6;
		if (corr(s, 1) == b && corr(s, 2) == b && corr(s, 4) == b)
			return GR_SURVIVOR;
		return GR_PREFINAL;
	endfunction

	function automatic logic [25:0] bump(input logic [25:0] c);
		return (c == '1) ? c : c + 26'd1;
	endfunction

	function automatic report_t mk_report(input logic [25:0] prin, input logic [25:0] pref,
			input logic [25:0] surv, input logic [25:0] first, input logic any);
		return {any, first, surv, pref, prin};
	endfunction

	// Update the counters for one accepted code; a last code closes the scan
	task automatic tally_code(input logic [25:0] code, input logic last);
		grade_e g;
		g = grade_code(code);
		if (g >= GR_PRINCIPAL)
			prin_tally = bump(prin_tally);
		if (g >= GR_PREFINAL)
			pref_tally = bump(pref_tally);
		if (g == GR_SURVIVOR) begin
			if (surv_tally == '0)
				first_code = code;
			surv_tally = bump(surv_tally);
		end
		if (last) begin
			scan_reports_q.push_back(mk_report(prin_tally, pref_tally, surv_tally,
				first_code, surv_tally != '0));
			prin_tally = '0;
			pref_tally = '0;
			surv_tally = '0;
			first_code = '0;
		end
	endtask

	function automatic logic [25:0] pack_entries(input int e [9]);
		logic [25:0] c;
		c = '0;
		for (int j = 8; j >= 0; j--)
			c = c * 26'd7 + 26'(e[j] + 3);
		return c;
	endfunction

	// Candidate codes shaped to reach the deeper filter stages
	function automatic logic [25:0] draw_code(input code_kind_e kind);
		int e [9];
		int ts, sum, a, b, c, j, k;
		ts = (want_target > 27) ? 27 : (want_target < -27) ? -27 : want_target;
		case (kind)
			K_NOISE: begin
				return 26'($urandom);
			end
			K_POOL: begin
				return survivor_pool[$urandom_range(survivor_pool.size() - 1)];
			end
			K_BALANCED: begin
				sum = 0;
				for (j = 0; j < 9; j++) begin
					e[j] = int'($urandom_range(6)) - 3;
					sum += e[j];
				end
				// walk the digit sum onto the target
				while (sum != ts) begin
					k = $urandom_range(8);
					if (sum < ts && e[k] < 3) begin
						e[k]++;
						sum++;
					end else if (sum > ts && e[k] > -3) begin
						e[k]--;
						sum--;
					end
				end
			end
			default: begin
				// period-3 entries with matching sum where the target allows
				a = int'($urandom_range(6)) - 3;
				b = int'($urandom_range(6)) - 3;
				c = int'($urandom_range(6)) - 3;
				if (ts % 3 == 0) begin
					for (j = 0; j < 8 && (ts / 3 - a - b > 3 || ts / 3 - a - b < -3); j++) begin
						a = int'($urandom_range(6)) - 3;
						b = int'($urandom_range(6)) - 3;
					end
					if (ts / 3 - a - b <= 3 && ts / 3 - a - b >= -3)
						c = ts / 3 - a - b;
				end
				for (j = 0; j < 9; j++)
					e[j] = (j % 3 == 0) ? a : (j % 3 == 1) ? b : c;
				if (kind == K_NUDGED) begin
					j = $urandom_range(8);
					k = (j + 1 + $urandom_range(7)) % 9;
					if (e[j] < 3 && e[k] > -3) begin
						e[j]++;
						e[k]--;
					end
				end
			end
		endcase
		return pack_entries(e);
	endfunction

	// Search for codes that pass at least the shift-3 check under this setting
	task automatic fill_pool();
		logic [25:0] c;
		survivor_pool.delete();
		for (int i = 0; i < 3000 && survivor_pool.size() < POOL_MAX; i++) begin
			c = draw_code((i % 2 == 0) ? K_BALANCED : K_NUDGED);
			if (grade_code(c) >= GR_PREFINAL)
				survivor_pool.push_back(c);
		end
	endtask

	// Idling follows the progress through the run
	task automatic update_idling();
		int mode;
		mode = items_sent * 3 / TOTAL_ITEMS;
		send_idle_pct = (mode == 0) ? 23 : (mode == 1) ? 76 : 0;
		recv_idle_pct = (mode == 0) ? 76 : (mode == 1) ? 23 : 0;
	endtask

	// One input transaction, with random idle cycles before it
	task automatic send_item(input logic [25:0] code, input logic last);
		update_idling();
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'd0, code};
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		tally_code(code, last);
		items_sent++;
	endtask

	// Wait until every report is in and the pipeline has emptied
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (scan_reports_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [5:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == bsaf_pkg::CFG_TARGET_SUM)
			want_target = int'($signed(data));
		else
			want_oml = int'(data[4:0]);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Output side: random back-pressure and checking against the oldest report
	always @(posedge clk) begin
		report_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[104:0];
			if (scan_reports_q.size() == 0) begin
				$display("%0t: unexpected report %h", $time, got);
				errors++;
			end else begin
				want = scan_reports_q.pop_front();
				if (got.principal_count != want.principal_count) begin
					$display("%0t: principal_count expected %0d got %0d", $time,
						want.principal_count, got.principal_count);
					errors++;
				end
				if (got.prefinal_count != want.prefinal_count) begin
					$display("%0t: prefinal_count expected %0d got %0d", $time,
						want.prefinal_count, got.prefinal_count);
					errors++;
				end
				if (got.survivor_count != want.survivor_count) begin
					$display("%0t: survivor_count expected %0d got %0d", $time,
						want.survivor_count, got.survivor_count);
					errors++;
				end
				if (got.first_code != want.first_code) begin
					$display("%0t: first_survivor_code expected %0d got %0d", $time,
						want.first_code, got.first_code);
					errors++;
				end
				if (got.any_survivor != want.any_survivor) begin
					$display("%0t: any_survivor expected %0b got %0b", $time,
						want.any_survivor, got.any_survivor);
					errors++;
				end
			end
		end
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Stimulus: directed rows, then random phases over several settings
	initial begin
		row_t        dir_rows [DIR_ROWS];
		logic [5:0]  ph_ts [RAND_PHASES];
		logic [5:0]  ph_oml [RAND_PHASES];
		logic [25:0] code;
		int          roll;
		code_kind_e  kind;

		dir_rows = '{
			'{ROW_ITEM, bsaf_pkg::CFG_TARGET_SUM, 6'd0, CODE_ALL_MIN, 1'b1, 1'b1, '0},
			'{ROW_ITEM, bsaf_pkg::CFG_TARGET_SUM, 6'd0, CODE_ALL_MAX, 1'b1, 1'b1, '0},
			'{ROW_ITEM, bsaf_pkg::CFG_TARGET_SUM, 6'd0, CODE_WRAP, 1'b1, 1'b1, '0},
			'{ROW_ITEM, bsaf_pkg::CFG_TARGET_SUM, 6'd0, CODE_SUM6, 1'b0, 1'b0, '0},
			'{ROW_ITEM, bsaf_pkg::CFG_TARGET_SUM, 6'd0, CODE_ZEROES, 1'b0, 1'b0, '0},
			'{ROW_ITEM, bsaf_pkg::CFG_TARGET_SUM, 6'd0, CODE_TOP, 1'b1, 1'b0, '0},
			'{ROW_CFG, bsaf_pkg::CFG_TARGET_SUM, 6'd37, '0, 1'b0, 1'b0, '0},
			'{ROW_CFG, bsaf_pkg::CFG_ORDER_MINUS_LAMBDA, 6'd0, '0, 1'b0, 1'b0, '0},
			// all entries -3 survive; the raw code 7^9 is kept
			'{ROW_ITEM, bsaf_pkg::CFG_TARGET_SUM, 6'd0, CODE_WRAP, 1'b0, 1'b0, '0},
			'{ROW_ITEM, bsaf_pkg::CFG_TARGET_SUM, 6'd0, CODE_ALL_MIN, 1'b1, 1'b1,
				mk_report(26'd2, 26'd2, 26'd2, CODE_WRAP, 1'b1)},
			'{ROW_CFG, bsaf_pkg::CFG_TARGET_SUM, 6'd27, '0, 1'b0, 1'b0, '0},
			'{ROW_ITEM, bsaf_pkg::CFG_TARGET_SUM, 6'd0, CODE_ALL_MAX, 1'b1, 1'b1,
				mk_report(26'd1, 26'd1, 26'd1, CODE_ALL_MAX, 1'b1)},
			'{ROW_CFG, bsaf_pkg::CFG_TARGET_SUM, 6'd18, '0, 1'b0, 1'b0, '0},
			'{ROW_ITEM, bsaf_pkg::CFG_TARGET_SUM, 6'd0, CODE_ALL_TWO, 1'b0, 1'b0, '0},
			'{ROW_ITEM, bsaf_pkg::CFG_TARGET_SUM, 6'd0, CODE_ALL_TWO, 1'b1, 1'b1,
				mk_report(26'd2, 26'd2, 26'd2, CODE_ALL_TWO, 1'b1)},
			// register values outside the stated range
			'{ROW_CFG, bsaf_pkg::CFG_TARGET_SUM, 6'd32, '0, 1'b0, 1'b0, '0},
			'{ROW_CFG, bsaf_pkg::CFG_ORDER_MINUS_LAMBDA, 6'd63, '0, 1'b0, 1'b0, '0},
			'{ROW_ITEM, bsaf_pkg::CFG_TARGET_SUM, 6'd0, CODE_TOP, 1'b0, 1'b0, '0},
			'{ROW_ITEM, bsaf_pkg::CFG_TARGET_SUM, 6'd0, CODE_ZEROES, 1'b1, 1'b0, '0},
			'{ROW_CFG, bsaf_pkg::CFG_TARGET_SUM, 6'd6, '0, 1'b0, 1'b0, '0},
			'{ROW_CFG, bsaf_pkg::CFG_ORDER_MINUS_LAMBDA, 6'd9, '0, 1'b0, 1'b0, '0},
			'{ROW_ITEM, bsaf_pkg::CFG_TARGET_SUM, 6'd0, CODE_SUM6, 1'b1, 1'b0, '0},
			'{ROW_ITEM, bsaf_pkg::CFG_TARGET_SUM, 6'd0, 26'h2AAAAAA, 1'b0, 1'b0, '0},
			'{ROW_ITEM, bsaf_pkg::CFG_TARGET_SUM, 6'd0, 26'h1555555, 1'b1, 1'b0, '0}
		};
		ph_ts  = '{6'd6, 6'd0, 6'd37, 6'd27, 6'd9, 6'd55, 6'd31, 6'd32, 6'd0, 6'd0};
		ph_oml = '{6'd9, 6'd0, 6'd0, 6'd0, 6'd0, 6'd27, 6'd31, 6'd32, 6'd0, 6'd0};
		ph_ts[8]  = 6'($urandom_range(63));
		ph_oml[8] = 6'($urandom_range(63));
		ph_ts[9]  = 6'($urandom_range(63));
		ph_oml[9] = 6'($urandom_range(63));

		// reset
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows
		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				wait_idle();
				write_reg(dir_rows[i].idx, dir_rows[i].data);
			end else begin
				send_item(dir_rows[i].code, dir_rows[i].last);
				if (dir_rows[i].typed)
					scan_reports_q[scan_reports_q.size() - 1] = dir_rows[i].rep;
			end
		end

		// random phases
		for (int p = 0; p < RAND_PHASES; p++) begin
			wait_idle();
			write_reg(bsaf_pkg::CFG_TARGET_SUM, ph_ts[p]);
			write_reg(bsaf_pkg::CFG_ORDER_MINUS_LAMBDA, ph_oml[p]);
			fill_pool();
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				roll = $urandom_range(99);
				kind = (roll < 35) ? K_BALANCED : (roll < 55) ? K_PERIODIC :
					(roll < 70) ? K_NUDGED : (roll < 85) ? K_POOL : K_NOISE;
				if (kind == K_POOL && survivor_pool.size() == 0)
					kind = K_BALANCED;
				code = draw_code(kind);
				send_item(code, $urandom_range(11) == 0);
			end
		end

		wait_idle();
		if (errors == 0)
			$display("PASS base7_sequence_autocorrelation_filter_core");
		else
			$display("FAIL base7_sequence_autocorrelation_filter_core");
		$finish;
	end

	// Watchdog
	initial begin
		#4000000;
		$display("FAIL base7_sequence_autocorrelation_filter_core");
		$finish;
	end

endmodule
